// ----- hw/rtl/feedback_comb_echo_unit_defines.svh -----
// Assertion macros for the feedback comb echo unit.
// Expects signals named clock and reset in the including module.
`ifndef FEEDBACK_COMB_ECHO_UNIT_DEFINES_SVH
`define FEEDBACK_COMB_ECHO_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FCE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define FCE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/fce_pkg.sv -----
// Shared constants and types for the feedback comb echo unit.
// No dependencies.
package fce_pkg;

   localparam int MAX_DELAY_DEF   = 32768;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int GAIN_W    = 16;
   localparam int GAIN_FRAC = 15;
   localparam int DELAY_W   = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register select, taken from paddr bit 2
   localparam logic REG_DELAY_SAMPLES = 1'b0;
   localparam logic REG_FEEDBACK_GAIN = 1'b1;

   typedef struct packed {
      logic bypass;      // zero delay: frame passes straight through
      logic zero_front;  // repeated slot of an empty line reads as zero
   } step_ctl_type;

endpackage

// ----- hw/rtl/fce_store.sv -----
// Delay line frame memory: one write port, one registered read port.
// No dependencies.
module fce_store #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fce_ctrl.sv -----
// Delay line bookkeeping: oldest pointer, real and repeated frame counts,
// resize on length change, read address and write slot per transaction.
// Depends on fce_pkg.
module fce_ctrl #(
   parameter int MAX_DELAY = fce_pkg::MAX_DELAY_DEF,
   parameter int PTR_W     = $clog2(MAX_DELAY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         step,
   input  logic [fce_pkg::DELAY_W-1:0]  delay_samples,
   output logic [PTR_W-1:0]             rd_addr,
   output logic [PTR_W-1:0]             wr_slot,
   output fce_pkg::step_ctl_type        ctl
);

   localparam int CNT_W = $clog2(MAX_DELAY + 1);
   localparam int TOT_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > fce_pkg::DELAY_W) ? CNT_W : fce_pkg::DELAY_W;
   localparam logic [TOT_W-1:0] MAX_T = TOT_W'(MAX_DELAY);

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] repeat_ff, repeat_in;

   logic [CNT_W-1:0] target;
   logic [TOT_W-1:0] total, tgt_t;
   logic [CNT_W-1:0] rep_r, fill_r, rep_n, fill_n;
   logic [PTR_W-1:0] ptr_n;
   logic [TOT_W-1:0] ptr_inc, slot_sum;
   logic             zero_front;

   always_comb begin
      if (CMP_W'(delay_samples) > CMP_W'(MAX_DELAY)) begin
         target = CNT_W'(MAX_DELAY);
      end else begin
         target = CNT_W'(delay_samples);
      end
   end

   assign total = TOT_W'(repeat_ff) + TOT_W'(fill_ff);
   assign tgt_t = TOT_W'(target);

   // resize to the configured length
   always_comb begin
      rep_r  = repeat_ff;
      fill_r = fill_ff;
      if (tgt_t > total) begin
         rep_r = CNT_W'(tgt_t - TOT_W'(fill_ff));
      end else if (tgt_t < total) begin
         priority if (fill_ff == '0) begin
            rep_r = target;
         end else if (target == '0) begin
            rep_r  = '0;
            fill_r = '0;
         end else if (target > repeat_ff) begin
            fill_r = target - repeat_ff;
         end else begin
            // keep the oldest real frame so repeated copies keep their value
            fill_r = CNT_W'(1);
            rep_r  = target - CNT_W'(1);
         end
      end
   end

   // pop the front frame (repeated or real)
   always_comb begin
      ptr_inc    = TOT_W'(ptr_ff) + TOT_W'(1);
      ptr_n      = ptr_ff;
      rep_n      = rep_r;
      fill_n     = fill_r;
      zero_front = 1'b0;
      if (rep_r != '0) begin
         zero_front = (fill_r == '0);
         rep_n      = rep_r - CNT_W'(1);
      end else begin
         ptr_n  = (ptr_inc >= MAX_T) ? PTR_W'(ptr_inc - MAX_T) : PTR_W'(ptr_inc);
         fill_n = fill_r - CNT_W'(1);
      end
      slot_sum = TOT_W'(ptr_n) + TOT_W'(fill_n);
      wr_slot  = (slot_sum >= MAX_T) ? PTR_W'(slot_sum - MAX_T) : PTR_W'(slot_sum);
   end

   assign rd_addr        = ptr_ff;
   assign ctl.bypass     = (target == '0);
   assign ctl.zero_front = zero_front;

   always_comb begin
      if (target == '0) begin
         ptr_in    = ptr_ff;
         fill_in   = fill_r;
         repeat_in = rep_r;
      end else begin
         ptr_in    = ptr_n;
         fill_in   = fill_n + CNT_W'(1);
         repeat_in = rep_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         fill_ff   <= '0;
         repeat_ff <= '0;
      end else if (step) begin
         ptr_ff    <= ptr_in;
         fill_ff   <= fill_in;
         repeat_ff <= repeat_in;
      end
   end

endmodule

// ----- hw/rtl/fce_lane.sv -----
// One channel: front sample times gain, round, add input, saturate; or bypass.
// Depends on fce_pkg.
module fce_lane #(
   parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
   input  logic signed [SAMPLE_BITS-1:0]      x,
   input  logic signed [SAMPLE_BITS-1:0]      front,
   input  logic signed [fce_pkg::GAIN_W-1:0]  gain,
   input  logic                               bypass,
   output logic signed [SAMPLE_BITS-1:0]      y
);

   localparam int PROD_W = SAMPLE_BITS + fce_pkg::GAIN_W;
   localparam int SUM_W  = SAMPLE_BITS + 3;
   localparam logic signed [PROD_W:0] ROUND =
      (PROD_W + 1)'(64'sd1 <<< (fce_pkg::GAIN_FRAC - 1));
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W:0]        biased;
   logic signed [SAMPLE_BITS+1:0] scaled;
   logic signed [SUM_W-1:0]       sum;

   assign prod   = front * gain;
   // round half up, then floor by the gain fraction
   assign biased = $signed({prod[PROD_W-1], prod}) + ROUND;
   assign scaled = biased[PROD_W:fce_pkg::GAIN_FRAC];
   assign sum    = $signed({{3{x[SAMPLE_BITS-1]}}, x}) + $signed({scaled[SAMPLE_BITS+1], scaled});

   always_comb begin
      priority if (bypass) begin
         y = x;
      end else if (sum > SAT_HI) begin
         y = SAMPLE_BITS'(SAT_HI);
      end else if (sum < SAT_LO) begin
         y = SAMPLE_BITS'(SAT_LO);
      end else begin
         y = SAMPLE_BITS'(sum);
      end
   end

endmodule

// ----- hw/rtl/feedback_comb_echo_unit.sv -----
// Stereo feedback comb filter (echo) over a delay line held in one frame memory.
// Depends on fce_pkg, fce_ctrl, fce_store, fce_lane and the assertion macro header.
//
// Takes one stereo frame per clock unless output stalls; results pass stage 1, then
// the output register. Throughput is set by the single read-modify-write of the
// frame memory, its registered read bypassed from the previous transaction's write
// when both hit the same slot. Output stalls back up through a single output
// register. The delay memory needs no clearing pass after reset: slots are only
// read once written, and an empty line feeds zeros. Registers: delay_samples at
// byte address 0 (0 = pass-through, values above MAX_DELAY act as MAX_DELAY),
// feedback_gain (signed Q1.15) at byte address 4; write them only while idle.
`include "feedback_comb_echo_unit_defines.svh"

module feedback_comb_echo_unit #(
   parameter int MAX_DELAY   = fce_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_BITS = fce_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]        req_right_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]        rsp_right_out,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fce_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [fce_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [fce_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   localparam int PTR_W  = $clog2(MAX_DELAY);
   localparam int DATA_W = 2 * SAMPLE_BITS;
   localparam int DW     = fce_pkg::DELAY_W;
   localparam int GW     = fce_pkg::GAIN_W;

   // configuration registers
   logic [DW-1:0]        delay_samples_ff;
   logic signed [GW-1:0] feedback_gain_ff;
   logic                 csr_wr;

   // stage 1: memory read returned, arithmetic, write back
   logic                          s1_valid_ff, s1_valid_in;
   fce_pkg::step_ctl_type         s1_ctl_ff;
   logic [PTR_W-1:0]              s1_slot_ff;
   logic signed [SAMPLE_BITS-1:0] s1_left_ff, s1_right_ff;
   logic                          fwd_ff, fwd_in;
   logic [DATA_W-1:0]             fwd_data_ff;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;

   logic                          req_fire, s1_adv, mem_we;
   fce_pkg::step_ctl_type         ctl;
   logic [PTR_W-1:0]              rd_addr, wr_slot;
   logic [DATA_W-1:0]             rd_data, front_word;
   logic signed [SAMPLE_BITS-1:0] y_left, y_right;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_samples_ff <= '0;
         feedback_gain_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            fce_pkg::REG_DELAY_SAMPLES: delay_samples_ff <= csr_pwdata[DW-1:0];
            fce_pkg::REG_FEEDBACK_GAIN: feedback_gain_ff <= $signed(csr_pwdata[GW-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         fce_pkg::REG_DELAY_SAMPLES:
            csr_prdata = {{(fce_pkg::CSR_DATA_W - DW){1'b0}}, delay_samples_ff};
         fce_pkg::REG_FEEDBACK_GAIN:
            csr_prdata = {{(fce_pkg::CSR_DATA_W - GW){feedback_gain_ff[GW-1]}},
                          feedback_gain_ff};
         default: csr_prdata = '0;
      endcase
   end

   // handshake
   assign s1_adv    = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign req_fire  = req_valid & req_ready;
   assign mem_we    = s1_adv & ~s1_ctl_ff.bypass;

   fce_ctrl #(
      .MAX_DELAY (MAX_DELAY),
      .PTR_W     (PTR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (req_fire),
      .delay_samples (delay_samples_ff),
      .rd_addr       (rd_addr),
      .wr_slot       (wr_slot),
      .ctl           (ctl)
   );

   fce_store #(
      .DEPTH  (MAX_DELAY),
      .ADDR_W (PTR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (s1_slot_ff),
      .wr_data ({y_right, y_left}),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // previous transaction writes the slot this one reads at the same edge
   assign fwd_in = mem_we & (s1_slot_ff == rd_addr);

   always_comb begin
      priority if (s1_ctl_ff.zero_front) begin
         front_word = '0;
      end else if (fwd_ff) begin
         front_word = fwd_data_ff;
      end else begin
         front_word = rd_data;
      end
   end

   fce_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_left (
      .x      (s1_left_ff),
      .front  ($signed(front_word[SAMPLE_BITS-1:0])),
      .gain   (feedback_gain_ff),
      .bypass (s1_ctl_ff.bypass),
      .y      (y_left)
   );

   fce_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_lane_right (
      .x      (s1_right_ff),
      .front  ($signed(front_word[DATA_W-1:SAMPLE_BITS])),
      .gain   (feedback_gain_ff),
      .bypass (s1_ctl_ff.bypass),
      .y      (y_right)
   );

   assign s1_valid_in  = req_fire | (s1_valid_ff & ~s1_adv);
   assign rsp_valid_in = s1_adv | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctl_ff   <= ctl;
         s1_slot_ff  <= wr_slot;
         s1_left_ff  <= req_left_in;
         s1_right_ff <= req_right_in;
         fwd_data_ff <= {y_right, y_left};
      end
      if (s1_adv) begin
         rsp_left_ff  <= y_left;
         rsp_right_ff <= y_right;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   `FCE_ASSERT_IMPLY(a_no_overrun, req_fire && s1_valid_ff, s1_adv, "stage 1 overwritten")
   `FCE_ASSERT_NEXT(a_stage_load, req_fire, s1_valid_ff, "accepted transaction lost")
   `FCE_ASSERT_NEXT(a_result_load, s1_adv, rsp_valid_ff && (rsp_left_out == $past(y_left)), "result not registered")

endmodule
